[rtl/tisd_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tisd_pkg
// Shared types, constants and helper functions for the terminal input
// sequence decoder.
// ----------------------------------------------------------------------------
package tisd_pkg;

  localparam logic [7:0] MAX_CHUNK = 8'd31;
  localparam int         NUM_KEYS  = 22;

  localparam logic [7:0] ESC_BYTE   = 8'h1B;
  localparam logic [7:0] CHAR_LBRKT = 8'h5B;
  localparam logic [7:0] CHAR_LT    = 8'h3C;
  localparam logic [7:0] CHAR_SEMI  = 8'h3B;
  localparam logic [7:0] CHAR_0     = 8'h30;
  localparam logic [7:0] CHAR_9     = 8'h39;
  localparam logic [7:0] CHAR_UP_M  = 8'h4D;
  localparam logic [7:0] CHAR_LO_M  = 8'h6D;

  localparam logic [9:0] BTN_WHEEL_UP   = 10'd64;
  localparam logic [9:0] BTN_WHEEL_DOWN = 10'd65;
  localparam logic [1:0] BTN_LOW_HOVER  = 2'b11;

  localparam logic [2:0] EV_ERROR   = 3'd0;
  localparam logic [2:0] EV_KEY     = 3'd1;
  localparam logic [2:0] EV_SPECIAL = 3'd2;
  localparam logic [2:0] EV_SCROLL  = 3'd3;
  localparam logic [2:0] EV_CLICK   = 3'd4;
  localparam logic [2:0] EV_HOVER   = 3'd5;
  localparam logic [2:0] EV_RELEASE = 3'd6;

  // {length[1:0], text0, text1, text2}
  localparam logic [25:0] KEY_TABLE [0:NUM_KEYS-1] = '{
    {2'd1, 8'h41, 8'h00, 8'h00}, {2'd1, 8'h42, 8'h00, 8'h00},
    {2'd1, 8'h43, 8'h00, 8'h00}, {2'd1, 8'h44, 8'h00, 8'h00},
    {2'd2, 8'h31, 8'h7E, 8'h00}, {2'd2, 8'h32, 8'h7E, 8'h00},
    {2'd2, 8'h33, 8'h7E, 8'h00}, {2'd2, 8'h34, 8'h7E, 8'h00},
    {2'd2, 8'h35, 8'h7E, 8'h00}, {2'd2, 8'h36, 8'h7E, 8'h00},
    {2'd3, 8'h31, 8'h31, 8'h7E}, {2'd3, 8'h31, 8'h32, 8'h7E},
    {2'd3, 8'h31, 8'h33, 8'h7E}, {2'd3, 8'h31, 8'h34, 8'h7E},
    {2'd3, 8'h31, 8'h35, 8'h7E}, {2'd3, 8'h31, 8'h37, 8'h7E},
    {2'd3, 8'h31, 8'h38, 8'h7E}, {2'd3, 8'h31, 8'h39, 8'h7E},
    {2'd3, 8'h32, 8'h30, 8'h7E}, {2'd3, 8'h32, 8'h31, 8'h7E},
    {2'd3, 8'h32, 8'h33, 8'h7E}, {2'd3, 8'h32, 8'h34, 8'h7E}
  };

  typedef struct packed {
    logic [7:0] byte_value;
    logic       chunk_end;
  } in_req_t;

  typedef struct packed {
    logic [2:0]         event_kind;
    logic [7:0]         key_char;
    logic [4:0]         key_code;
    logic [15:0]        mouse_column;
    logic [15:0]        mouse_row;
    logic [1:0]         mouse_button;
    logic signed [15:0] scroll_total;
  } out_req_t;

  typedef struct packed {
    logic out_full;
    logic skid_full;
  } buf_status_t;

  function automatic logic [15:0] dec_step16(input logic [15:0] acc,
                                             input logic [3:0]  dig);
    logic [19:0] v;
    v = (20'(acc) << 3) + (20'(acc) << 1) + 20'(dig);
    return (v > 20'd65535) ? 16'hFFFF : v[15:0];
  endfunction

  function automatic logic [9:0] dec_step10(input logic [9:0] acc,
                                            input logic [3:0] dig);
    logic [13:0] v;
    v = (14'(acc) << 3) + (14'(acc) << 1) + 14'(dig);
    return (v > 14'd1023) ? 10'd1023 : v[9:0];
  endfunction

  // returns {hit, index}; lowest index wins
  function automatic logic [5:0] key_match(input logic [1:0] len,
                                           input logic [7:0] c0,
                                           input logic [7:0] c1,
                                           input logic [7:0] c2);
    logic [5:0]  res;
    logic [25:0] ent;
    res = 6'd0;
    for (int i = NUM_KEYS - 1; i >= 0; i--) begin
      ent = KEY_TABLE[i];
      if (ent[25:24] == len && ent[23:16] == c0 &&
          (len < 2'd2 || ent[15:8] == c1) &&
          (len < 2'd3 || ent[7:0] == c2)) begin
        res = {1'b1, 5'(i)};
      end
    end
    return res;
  endfunction

endpackage

[rtl/tisd_parser.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tisd_parser
// Per-byte chunk parser: keeps the chunk state and the scroll count, and
// builds the decoded event on the last byte of a chunk.
// ----------------------------------------------------------------------------
module tisd_parser (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               step_valid,
  input  tisd_pkg::in_req_t  step_req,
  output logic               push,
  output tisd_pkg::out_req_t push_req
);

  localparam logic [2:0] PH_PREFIX   = 3'd0;
  localparam logic [2:0] PH_BTN_FST  = 3'd1;
  localparam logic [2:0] PH_BTN_MORE = 3'd2;
  localparam logic [2:0] PH_COL_FST  = 3'd3;
  localparam logic [2:0] PH_COL_MORE = 3'd4;
  localparam logic [2:0] PH_ROW_FST  = 3'd5;
  localparam logic [2:0] PH_ROW_MORE = 3'd6;
  localparam logic [2:0] PH_FINAL    = 3'd7;

  logic [7:0]         byte_count_r, byte_count_nxt;
  logic [7:0]         lead_r [0:4];
  logic [2:0]         phase_r, phase_nxt;
  logic [9:0]         button_r, button_nxt;
  logic [15:0]        column_r, column_nxt;
  logic [15:0]        row_r, row_nxt;
  logic [7:0]         final_r, final_nxt;
  logic               mvalid_r, mvalid_nxt;
  logic signed [15:0] scroll_r, scroll_nxt;

  logic [7:0]         b;
  logic [7:0]         idx;
  logic [7:0]         lead_eff [0:4];
  logic               dig;
  logic [3:0]         dval;
  logic               csi;
  logic [5:0]         km;
  logic               mouse_ok;
  tisd_pkg::out_req_t ev;

  assign b   = step_req.byte_value;
  assign idx = byte_count_r;

  always_comb begin
    for (int i = 0; i < 5; i++) begin
      lead_eff[i] = (idx == 8'(i)) ? b : lead_r[i];
    end
  end

  assign dig  = (b >= tisd_pkg::CHAR_0) && (b <= tisd_pkg::CHAR_9);
  assign dval = dig ? b[3:0] : 4'd0;

  always_comb begin
    byte_count_nxt = (idx != 8'd255) ? idx + 8'd1 : 8'd255;
    phase_nxt  = phase_r;
    button_nxt = button_r;
    column_nxt = column_r;
    row_nxt    = row_r;
    final_nxt  = final_r;
    mvalid_nxt = mvalid_r;
    if (idx == 8'd2) begin
      if (lead_r[0] == tisd_pkg::ESC_BYTE && lead_r[1] == tisd_pkg::CHAR_LBRKT &&
          b == tisd_pkg::CHAR_LT) begin
        mvalid_nxt = 1'b1;
        phase_nxt  = PH_BTN_FST;
      end
    end else if (idx > 8'd2 && mvalid_r) begin
      case (phase_r)
        PH_BTN_FST: begin
          if (dig) begin
            button_nxt = 10'(dval);
            phase_nxt  = PH_BTN_MORE;
          end else begin
            mvalid_nxt = 1'b0;
          end
        end
        PH_BTN_MORE: begin
          if (dig) button_nxt = tisd_pkg::dec_step10(button_r, dval);
          else if (b == tisd_pkg::CHAR_SEMI) phase_nxt = PH_COL_FST;
          else mvalid_nxt = 1'b0;
        end
        PH_COL_FST: begin
          if (dig) begin
            column_nxt = 16'(dval);
            phase_nxt  = PH_COL_MORE;
          end else begin
            mvalid_nxt = 1'b0;
          end
        end
        PH_COL_MORE: begin
          if (dig) column_nxt = tisd_pkg::dec_step16(column_r, dval);
          else if (b == tisd_pkg::CHAR_SEMI) phase_nxt = PH_ROW_FST;
          else mvalid_nxt = 1'b0;
        end
        PH_ROW_FST: begin
          if (dig) begin
            row_nxt   = 16'(dval);
            phase_nxt = PH_ROW_MORE;
          end else begin
            mvalid_nxt = 1'b0;
          end
        end
        PH_ROW_MORE: begin
          if (dig) begin
            row_nxt = tisd_pkg::dec_step16(row_r, dval);
          end else begin
            final_nxt = b;
            phase_nxt = PH_FINAL;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // end-of-chunk classification on the updated state
  assign csi = (byte_count_nxt >= 8'd2) && (lead_eff[0] == tisd_pkg::ESC_BYTE) &&
               (lead_eff[1] == tisd_pkg::CHAR_LBRKT);
  assign km  = tisd_pkg::key_match(byte_count_nxt[1:0] - 2'd2,
                                   lead_eff[2], lead_eff[3], lead_eff[4]);
  assign mouse_ok = mvalid_nxt && (phase_nxt == PH_FINAL);

  always_comb begin
    ev = '0;
    ev.event_kind = tisd_pkg::EV_ERROR;
    scroll_nxt = scroll_r;
    if (byte_count_nxt > tisd_pkg::MAX_CHUNK) begin
      ev.event_kind = tisd_pkg::EV_ERROR;
    end else if (csi && byte_count_nxt >= 8'd3 && lead_eff[2] == tisd_pkg::CHAR_LT) begin
      if (mouse_ok) begin
        if (button_nxt == tisd_pkg::BTN_WHEEL_UP) begin
          ev.event_kind = tisd_pkg::EV_SCROLL;
          if (scroll_r != 16'sh7FFF) scroll_nxt = scroll_r + 16'sd1;
        end else if (button_nxt == tisd_pkg::BTN_WHEEL_DOWN) begin
          ev.event_kind = tisd_pkg::EV_SCROLL;
          if (scroll_r != -16'sh8000) scroll_nxt = scroll_r - 16'sd1;
        end else if (final_nxt == tisd_pkg::CHAR_UP_M) begin
          ev.event_kind = (button_nxt[1:0] == tisd_pkg::BTN_LOW_HOVER) ?
                          tisd_pkg::EV_HOVER : tisd_pkg::EV_CLICK;
        end else if (final_nxt == tisd_pkg::CHAR_LO_M) begin
          ev.event_kind = tisd_pkg::EV_RELEASE;
        end
        if (ev.event_kind != tisd_pkg::EV_ERROR) begin
          ev.mouse_column = column_nxt;
          ev.mouse_row    = row_nxt;
          ev.mouse_button = button_nxt[1:0];
        end
      end
    end else if (csi && byte_count_nxt >= 8'd3 && byte_count_nxt <= 8'd5 && km[5]) begin
      ev.event_kind = tisd_pkg::EV_SPECIAL;
      ev.key_code   = km[4:0];
    end else if (byte_count_nxt == 8'd1) begin
      ev.event_kind = tisd_pkg::EV_KEY;
      ev.key_char   = lead_eff[0];
    end
    ev.scroll_total = scroll_nxt;
  end

  assign push     = step_valid && step_req.chunk_end;
  assign push_req = ev;

  always_ff @(posedge clk) begin
    if (step_valid && idx < 8'd5) begin
      lead_r[idx[2:0]] <= b;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_count_r <= '0;
      phase_r      <= PH_PREFIX;
      button_r     <= '0;
      column_r     <= '0;
      row_r        <= '0;
      final_r      <= '0;
      mvalid_r     <= 1'b0;
      scroll_r     <= '0;
    end else if (step_valid) begin
      if (step_req.chunk_end) begin
        byte_count_r <= '0;
        phase_r      <= PH_PREFIX;
        button_r     <= '0;
        column_r     <= '0;
        row_r        <= '0;
        final_r      <= '0;
        mvalid_r     <= 1'b0;
        scroll_r     <= scroll_nxt;
      end else begin
        byte_count_r <= byte_count_nxt;
        phase_r      <= phase_nxt;
        button_r     <= button_nxt;
        column_r     <= column_nxt;
        row_r        <= row_nxt;
        final_r      <= final_nxt;
        mvalid_r     <= mvalid_nxt;
      end
    end
  end

endmodule

[rtl/tisd_out_buf.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tisd_out_buf
// Result register with one skid entry behind it.
// ----------------------------------------------------------------------------
module tisd_out_buf (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  push,
  input  tisd_pkg::out_req_t    push_req,
  input  logic                  out_stall,
  output logic                  out_valid,
  output tisd_pkg::out_req_t    out_req,
  output tisd_pkg::buf_status_t status
);

  logic               out_valid_r;
  tisd_pkg::out_req_t out_req_r;
  logic               skid_valid_r;
  tisd_pkg::out_req_t skid_req_r;
  logic               pop;

  assign pop = out_valid_r && !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (!out_valid_r || pop) begin
      if (skid_valid_r) begin
        out_valid_r  <= 1'b1;
        skid_valid_r <= push;
      end else begin
        out_valid_r  <= push;
      end
    end else if (push) begin
      skid_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid_r || pop) begin
      if (skid_valid_r) begin
        out_req_r  <= skid_req_r;
        skid_req_r <= push_req;
      end else if (push) begin
        out_req_r  <= push_req;
      end
    end else if (push) begin
      skid_req_r <= push_req;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_req          = out_req_r;
  assign status.out_full  = out_valid_r;
  assign status.skid_full = skid_valid_r;

  a_skid_behind_out : assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid entry without result register");

  a_no_overflow : assert property (@(posedge clk) disable iff (!rst_n)
    (push && out_valid_r && !pop) |-> !skid_valid_r)
    else $error("request pushed into full buffer");

  a_drain_empty : assert property (@(posedge clk) disable iff (!rst_n)
    (pop && !skid_valid_r && !push) |=> !out_valid_r)
    else $error("result register not emptied after pop");

endmodule

[rtl/terminal_input_sequence_decoder_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// terminal_input_sequence_decoder_unit
// Decodes terminal read chunks (keys, special keys, SGR mouse reports).
// ----------------------------------------------------------------------------
// Usage:
//   in_valid/in_req carry one byte of a read chunk per request, with
//   chunk_end set on the last byte. Exactly one event request leaves on
//   out_valid/out_req for each chunk_end byte; other bytes give none.
//   A byte is captured in the input register, parsed in the next cycle and
//   its event loaded into the result register, or into the skid entry when
//   the result register stays full. One byte per cycle is taken while in_stall is low.
//   The result register has a one-entry skid behind it; in_stall rises when
//   the result register is full and either out_stall is high with a second
//   request or a byte in flight, or the skid is full with a byte in flight,
//   so with out_stall held high the block stops after at most two pending
//   events. A stalled result holds.
//   Synchronous reset clears the chunk state, the scroll count and both
//   handshake stages; no clearing pass is needed.
// ----------------------------------------------------------------------------
module terminal_input_sequence_decoder_unit (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  tisd_pkg::in_req_t  in_req,
  output logic               out_valid,
  input  logic               out_stall,
  output tisd_pkg::out_req_t out_req
);

  logic                  s1_valid_r;
  tisd_pkg::in_req_t     s1_req_r;
  logic                  push;
  tisd_pkg::out_req_t    push_req;
  tisd_pkg::buf_status_t buf_status;

  // stall when out is full and either out_stall is high with skid or in-flight byte occupied, or both of those are
  assign in_stall = buf_status.out_full &&
                    ((out_stall && (buf_status.skid_full || s1_valid_r)) ||
                     (buf_status.skid_full && s1_valid_r));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= in_valid && !in_stall;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_req_r <= in_req;
    end
  end

  tisd_parser u_parser (
    .clk        (clk),
    .rst_n      (rst_n),
    .step_valid (s1_valid_r),
    .step_req   (s1_req_r),
    .push       (push),
    .push_req   (push_req)
  );

  tisd_out_buf u_out_buf (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_req  (push_req),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_req   (out_req),
    .status    (buf_status)
  );

endmodule
